### design/log_decade_histogram_stats_macros.svh
// assertion macros for the log decade histogram block
`ifndef LOG_DECADE_HISTOGRAM_STATS_MACROS_SVH
`define LOG_DECADE_HISTOGRAM_STATS_MACROS_SVH

// same-cycle implication, checked outside reset
`define LDH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LDH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ldh_pkg.sv
// package with widths, opcodes and bucket edge functions for the histogram block
package ldh_pkg;

	localparam int OPCODE_W = 2;
	localparam int SAMPLE_W = 32;
	localparam int BUCKET_W = 6;
	localparam int REPORT_W = 32;
	localparam int SUM_W = 64;

	localparam int DECADES_DEFAULT = 6;
	localparam int COUNT_BITS_DEFAULT = 32;
	localparam int MAX_DECADES = 9;

	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

	// upper multiple of the decade base for each bucket inside a decade
	function automatic logic [63:0] edge_mult(input int unsigned k);
		logic [63:0] m;
		case (k)
			0: m = 64'd2;
			1: m = 64'd3;
			2: m = 64'd4;
			3: m = 64'd6;
			4: m = 64'd8;
			default: m = 64'd10;
		endcase
		return m;
	endfunction

	// lower edge in ns of bucket j+1
	function automatic logic [63:0] edge_ns(input int unsigned j);
		logic [63:0] base;
		int unsigned r;
		base = 64'd1000;
		r = j;
		if (r != 0) begin
			r = r - 1;
			for (int d = 0; d < MAX_DECADES; d++) begin
				if (r >= 6) begin
					r = r - 6;
					base = base * 64'd10;
				end
			end
			base = base * edge_mult(r);
		end
		return base;
	endfunction

endpackage

### design/ldh_in_if.sv
// request channel interface: opcode, sample and bucket select
interface ldh_in_if;
	import ldh_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [SAMPLE_W-1:0] sample_ns;
	logic [BUCKET_W-1:0] bucket_select;

	modport source (output valid, opcode, sample_ns, bucket_select, input ready);
	modport sink (input valid, opcode, sample_ns, bucket_select, output ready);
endinterface

### design/ldh_out_if.sv
// result channel interface: bucket count and running statistics
interface ldh_out_if;
	import ldh_pkg::*;

	logic                valid;
	logic                ready;
	logic [BUCKET_W-1:0] bucket_index;
	logic [REPORT_W-1:0] bucket_count;
	logic [REPORT_W-1:0] sample_count;
	logic [SAMPLE_W-1:0] min_ns;
	logic [SAMPLE_W-1:0] max_ns;
	logic [SUM_W-1:0]    sum_ns;

	modport source (output valid, bucket_index, bucket_count, sample_count, min_ns, max_ns,
		sum_ns, input ready);
	modport sink (input valid, bucket_index, bucket_count, sample_count, min_ns, max_ns,
		sum_ns, output ready);
endinterface

### design/ldh_ram.sv
// generic single-write, registered-read RAM
module ldh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 38
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### design/ldh_bucket.sv
// bucket selection by parallel compare against the decade edges
module ldh_bucket #(
	parameter int DECADES = ldh_pkg::DECADES_DEFAULT
) (
	input  logic [ldh_pkg::SAMPLE_W-1:0] sample_ns,
	output logic [ldh_pkg::BUCKET_W-1:0] bucket
);
	import ldh_pkg::*;

	localparam int NEDGE = 6 * DECADES + 1;

	// edges rise monotonically, so the last edge passed names the bucket
	always_comb begin
		bucket = '0;
		for (int j = 0; j < NEDGE; j++) begin
			if (64'(sample_ns) >= edge_ns(j)) begin
				bucket = BUCKET_W'(j + 1);
			end
		end
	end
endmodule

### design/log_decade_histogram_stats.sv
// latency histogram top level: one item accepted per cycle unless the output stalls, no stall of its own
// a result passes from the stage 1 register into the output register, and waits in stage 1 on stall
// bucket counters live in a RAM read at acceptance and written back as an add leaves stage 1
// a same-bucket write-back is forwarded, so back-to-back adds count correctly
// reset and the clear opcode zero all statistics and per-bucket valid flags at once
`include "log_decade_histogram_stats_macros.svh"
module log_decade_histogram_stats #(
	parameter int DECADES = ldh_pkg::DECADES_DEFAULT,
	parameter int COUNT_BITS = ldh_pkg::COUNT_BITS_DEFAULT
) (
	input logic      clk,
	input logic      arst_n,
	ldh_in_if.sink   req,
	ldh_out_if.source rsp
);
	import ldh_pkg::*;

	localparam int NB = 6 * DECADES + 2;
	localparam int AW = $clog2(NB);

	function automatic logic [REPORT_W-1:0] report32(input logic [COUNT_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (|w[63:REPORT_W]) ? '1 : w[REPORT_W-1:0];
	endfunction

	// handshake
	logic req_fire, s1_fire, out_take;

	// stage 0
	logic [BUCKET_W-1:0] bkt;
	logic [BUCKET_W-1:0] idx_nxt;
	logic                inrange_nxt;
	logic [AW-1:0]       addr_nxt;

	// stage 1
	logic                  valid_s1;
	logic [OPCODE_W-1:0]   op_s1;
	logic [SAMPLE_W-1:0]   sample_s1;
	logic [BUCKET_W-1:0]   idx_s1;
	logic [AW-1:0]         addr_s1;
	logic                  inrange_s1;
	logic                  fwd_hit_s1;
	logic [COUNT_BITS-1:0] fwd_data_s1;

	// state
	logic [NB-1:0]         cnt_valid_q;
	logic [SAMPLE_W-1:0]   min_q, max_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [COUNT_BITS-1:0] rdata, old_cnt, new_cnt, res_cnt;
	logic [SAMPLE_W-1:0]   min_nxt, max_nxt;
	logic [SUM_W-1:0]      sum_nxt;
	logic [SUM_W:0]        sum_ext;
	logic [COUNT_BITS-1:0] count_nxt;
	logic                  ram_we;

	// output register
	logic                rsp_valid_q;
	logic [BUCKET_W-1:0] idx_q;
	logic [REPORT_W-1:0] bcnt_q, scnt_q;
	logic [SAMPLE_W-1:0] rmin_q, rmax_q;
	logic [SUM_W-1:0]    rsum_q;

	assign out_take = !rsp_valid_q || rsp.ready;
	assign s1_fire = valid_s1 && out_take;
	assign req.ready = !valid_s1 || out_take;
	assign req_fire = req.valid && req.ready;

	ldh_bucket #(.DECADES(DECADES)) u_bucket (
		.sample_ns (req.sample_ns),
		.bucket    (bkt)
	);

	always_comb begin
		case (req.opcode)
			OP_ADD:  idx_nxt = bkt;
			OP_READ: idx_nxt = req.bucket_select;
			default: idx_nxt = '0;
		endcase
		inrange_nxt = idx_nxt < BUCKET_W'(NB);
		addr_nxt = inrange_nxt ? idx_nxt[AW-1:0] : '0;
	end

	ldh_ram #(.WIDTH(COUNT_BITS), .DEPTH(NB)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (new_cnt),
		.re    (req_fire),
		.raddr (addr_nxt),
		.rdata (rdata)
	);

	always_comb begin
		old_cnt = fwd_hit_s1 ? fwd_data_s1 : (cnt_valid_q[addr_s1] ? rdata : '0);
		new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_BITS'(1);
		sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sample_s1);
		min_nxt = min_q;
		max_nxt = max_q;
		sum_nxt = sum_q;
		count_nxt = count_q;
		res_cnt = inrange_s1 ? old_cnt : '0;
		case (op_s1)
			OP_CLEAR: begin
				min_nxt = '0;
				max_nxt = '0;
				sum_nxt = '0;
				count_nxt = '0;
				res_cnt = '0;
			end
			OP_ADD: begin
				if (count_q == '0 || sample_s1 < min_q) begin
					min_nxt = sample_s1;
				end
				if (sample_s1 > max_q) begin
					max_nxt = sample_s1;
				end
				sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
				count_nxt = (count_q == '1) ? count_q : count_q + COUNT_BITS'(1);
				res_cnt = new_cnt;
			end
			default: ;
		endcase
	end

	assign ram_we = s1_fire && op_s1 == OP_ADD;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
				fwd_hit_s1 <= ram_we && addr_s1 == addr_nxt;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
				fwd_hit_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1 <= req.opcode;
			sample_s1 <= req.sample_ns;
			idx_s1 <= idx_nxt;
			addr_s1 <= addr_nxt;
			inrange_s1 <= inrange_nxt;
			fwd_data_s1 <= new_cnt;
		end
	end

	// statistics and bucket valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_q <= '0;
			min_q <= '0;
			max_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else if (s1_fire) begin
			min_q <= min_nxt;
			max_q <= max_nxt;
			sum_q <= sum_nxt;
			count_q <= count_nxt;
			if (op_s1 == OP_CLEAR) begin
				cnt_valid_q <= '0;
			end else if (op_s1 == OP_ADD) begin
				cnt_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			idx_q <= (op_s1 == OP_CLEAR) ? '0 : idx_s1;
			bcnt_q <= report32(res_cnt);
			scnt_q <= report32(count_nxt);
			rmin_q <= min_nxt;
			rmax_q <= max_nxt;
			rsum_q <= sum_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.bucket_index = idx_q;
	assign rsp.bucket_count = bcnt_q;
	assign rsp.sample_count = scnt_q;
	assign rsp.min_ns = rmin_q;
	assign rsp.max_ns = rmax_q;
	assign rsp.sum_ns = rsum_q;

	`LDH_ASSERT_SAME(a_fwd_live, fwd_hit_s1, valid_s1, "forward flag without a live item")
	`LDH_ASSERT_SAME(a_no_overrun, valid_s1 && !s1_fire, !req_fire,
		"item accepted while stage 1 is stalled")
	`LDH_ASSERT_NEXT(a_clear_all, s1_fire && op_s1 == OP_CLEAR,
		cnt_valid_q == '0 && count_q == '0 && sum_q == '0, "clear left state behind")
	`LDH_ASSERT_NEXT(a_add_marks, s1_fire && op_s1 == OP_ADD,
		count_q != '0 && cnt_valid_q[$past(addr_s1)], "add did not update counters")
endmodule
